// ===== rtl/core/pid_ip_pkg.sv =====
// Package for the incremental/positional PID controller.
// Holds field widths, register indexes, reset values and payload structs.
// No dependencies; imported by pid_incremental_positional_top.
`default_nettype none

package pid_ip_pkg;

    // Data path widths.
    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Derived arithmetic widths.
    localparam int ERR_W   = DATA_W + 1;
    localparam int THIRD_W = (ERR_W > LIM_W + 1) ? ERR_W : LIM_W + 1;
    localparam int DIFF2_W = THIRD_W + 2;
    localparam int PROD_W  = GAIN_W + 1 + DIFF2_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int RUN_W   = LIM_W + FRAC_W;

    typedef enum logic {
        MODE_INC = 1'b0,
        MODE_POS = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_KP      = 3'd1,
        CFG_KI      = 3'd2,
        CFG_KD      = 3'd3,
        CFG_OUT_MAX = 3'd4,
        CFG_OUT_MIN = 3'd5,
        CFG_ILIM    = 3'd6
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [GAIN_W-1:0]       KP_RST      = 16'd512;
    localparam logic [GAIN_W-1:0]       KI_RST      = 16'd256;
    localparam logic [GAIN_W-1:0]       KD_RST      = 16'd0;
    localparam logic signed [LIM_W-1:0] OUT_MAX_RST = 16'sd499;
    localparam logic signed [LIM_W-1:0] OUT_MIN_RST = -16'sd499;
    localparam logic [LIM_W-1:0]        ILIM_RST    = 16'd50;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] target;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/core/pid_incremental_positional_top.sv =====
// PID controller, incremental and positional forms, one registered pass per sample.
// A sample is held in the input register, then passes one arithmetic stage of three
// multiplies, a sum and a clamp into the result register; a stalled output keeps it
// waiting in the input register.
// Throughput: one sample per cycle while the output is not stalled; the state feedback closes within that stage.
// Reset (synchronous, active low) clears all controller state and both valid
// flags, and loads the configuration registers with their default values.
`default_nettype none

module pid_incremental_positional_top
    import pid_ip_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data
);

    // Configuration registers.
    t_mode                    r_mode;
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic [GAIN_W-1:0]        r_kd;
    logic signed [LIM_W-1:0]  r_out_max;
    logic signed [LIM_W-1:0]  r_out_min;
    logic [LIM_W-1:0]         r_ilim;

    // Controller state.
    logic signed [ERR_W-1:0]   r_e1;
    logic signed [THIRD_W-1:0] r_third;
    logic signed [RUN_W-1:0]   r_run;

    // Pipeline registers.
    t_in  r_in;
    logic r_in_vld;
    t_out r_out;
    logic r_out_vld;
    t_out n_out;

    logic fire;

    // Arithmetic.
    logic signed [ERR_W-1:0]     err;
    logic signed [THIRD_W-1:0]   err_t;
    logic signed [THIRD_W-1:0]   e1_t;
    logic signed [THIRD_W:0]     d1;
    logic signed [DIFF2_W-1:0]   d2;
    logic signed [THIRD_W:0]     integ_sum;
    logic signed [THIRD_W:0]     lim_s;
    logic signed [THIRD_W:0]     neg_lim;
    logic signed [THIRD_W:0]     integ_hi;
    logic signed [THIRD_W:0]     integ_cl;
    logic signed [THIRD_W-1:0]   integ_new;
    logic signed [DIFF2_W-1:0]   op_p;
    logic signed [DIFF2_W-1:0]   op_i;
    logic signed [DIFF2_W-1:0]   op_d;
    logic signed [GAIN_W:0]      g_p;
    logic signed [GAIN_W:0]      g_i;
    logic signed [GAIN_W:0]      g_d;
    logic signed [PROD_W-1:0]    prod_p;
    logic signed [PROD_W-1:0]    prod_i;
    logic signed [PROD_W-1:0]    prod_d;
    logic signed [ACC_W-1:0]     base;
    logic signed [ACC_W-1:0]     v_sum;
    logic signed [ACC_W-1:0]     hi_fx;
    logic signed [ACC_W-1:0]     lo_fx;
    logic signed [ACC_W-1:0]     v_hi;
    logic signed [ACC_W-1:0]     v_cl;
    logic                        hit_hi;
    logic                        hit_lo;
    logic signed [RUN_W-1:0]     v_res;
    logic signed [LIM_W-1:0]     drive_w;

    // Handshake: the input register refills whenever its item moves on.
    assign fire        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || fire;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        err   = ERR_W'($signed(r_in.target)) - ERR_W'($signed(r_in.measured));
        err_t = THIRD_W'(err);
        e1_t  = THIRD_W'(r_e1);
        d1    = (THIRD_W+1)'(err_t) - (THIRD_W+1)'(e1_t);
        d2    = DIFF2_W'(err_t) - (DIFF2_W'(e1_t) <<< 1) + DIFF2_W'(r_third);

        // Positional integral, clamped to the symmetric limit.
        integ_sum = (THIRD_W+1)'(r_third) + (THIRD_W+1)'(err_t);
        lim_s     = (THIRD_W+1)'($signed({1'b0, r_ilim}));
        neg_lim   = -lim_s;
        integ_hi  = (integ_sum > lim_s) ? lim_s : integ_sum;
        integ_cl  = (integ_hi < neg_lim) ? neg_lim : integ_hi;
        integ_new = THIRD_W'(integ_cl);

        // Both forms share the three multipliers; only the operands and the base term differ.
        if (r_mode == MODE_POS) begin
            op_p = DIFF2_W'(err_t);
            op_i = DIFF2_W'(integ_new);
            op_d = DIFF2_W'(d1);
            base = '0;
        end else begin
            op_p = DIFF2_W'(d1);
            op_i = DIFF2_W'(err_t);
            op_d = d2;
            base = ACC_W'(r_run);
        end

        g_p = $signed({1'b0, r_kp});
        g_i = $signed({1'b0, r_ki});
        g_d = $signed({1'b0, r_kd});

        prod_p = PROD_W'(g_p) * PROD_W'(op_p);
        prod_i = PROD_W'(g_i) * PROD_W'(op_i);
        prod_d = PROD_W'(g_d) * PROD_W'(op_d);

        v_sum = base + ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

        // Upper limit first, then lower, so crossed limits give the lower one.
        hi_fx  = ACC_W'(r_out_max) <<< FRAC_W;
        lo_fx  = ACC_W'(r_out_min) <<< FRAC_W;
        hit_hi = v_sum > hi_fx;
        v_hi   = hit_hi ? hi_fx : v_sum;
        hit_lo = v_hi < lo_fx;
        v_cl   = hit_lo ? lo_fx : v_hi;
        v_res  = RUN_W'(v_cl);

        // Arithmetic shift floors the fraction.
        drive_w       = LIM_W'(v_res >>> FRAC_W);
        n_out.drive   = DATA_W'(drive_w);
        n_out.clamped = hit_hi || hit_lo;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INC;
            r_kp      <= KP_RST;
            r_ki      <= KI_RST;
            r_kd      <= KD_RST;
            r_out_max <= OUT_MAX_RST;
            r_out_min <= OUT_MIN_RST;
            r_ilim    <= ILIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[0]);
                CFG_KP:      r_kp      <= i_cfg_data;
                CFG_KI:      r_ki      <= i_cfg_data;
                CFG_KD:      r_kd      <= i_cfg_data;
                CFG_OUT_MAX: r_out_max <= $signed(i_cfg_data);
                CFG_OUT_MIN: r_out_min <= $signed(i_cfg_data);
                CFG_ILIM:    r_ilim    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_e1      <= '0;
            r_third   <= '0;
            r_run     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
                r_e1      <= err;
                if (r_mode == MODE_POS) begin
                    r_third <= integ_new;
                end else begin
                    r_third <= e1_t;
                    r_run   <= v_res;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // An item held in the input register is never dropped before it is processed.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !fire |=> r_in_vld)
        else $error("input register lost a pending transaction");

    // A taken result with nothing behind it leaves the output register empty.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_ready && !fire |=> !r_out_vld)
        else $error("output register repeated a transaction");

    // Incremental form shifts the previous error into the older-error slot.
    a_inc_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_mode == MODE_INC |=> r_third == THIRD_W'($past(r_e1)))
        else $error("older error not shifted");

    // Positional integral stays within its symmetric limit.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_mode == MODE_POS |=>
            ((THIRD_W+1)'(r_third) <= lim_s) && ((THIRD_W+1)'(r_third) >= neg_lim))
        else $error("integral outside its limit");

endmodule

`default_nettype wire

// ===== dv/pid_incremental_positional_top_test.sv =====
// Self-checking testbench for pid_incremental_positional_top: random samples, gains and limits.
// A predictor of the controller in both forms computes the expected drive and clamp flag.
// Depends on pid_ip_pkg and pid_incremental_positional_top only.
`default_nettype none

module pid_incremental_positional_top_test;
    import pid_ip_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;

    pid_incremental_positional_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration registers.
    t_mode                     gain_mode;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic signed [LIM_W-1:0]   drive_max;
    logic signed [LIM_W-1:0]   drive_min;
    logic [LIM_W-1:0]          integral_cap;

    // Controller state as the block keeps it.
    logic signed [ERR_W-1:0]   err_prev;
    logic signed [THIRD_W-1:0] err_older_or_integral;
    logic signed [RUN_W-1:0]   drive_accum;

    t_in  samples_pending[$];
    t_out drive_expected[$];
    int   samples_owed = 0;
    int   failures     = 0;
    int   idle_cycles  = 0;
    int   in_gap       = 0;
    int   out_stall    = 0;
    bit   in_quiet     = 1'b0;
    bit   out_quiet    = 1'b0;
    logic in_taken     = 1'b0;
    t_out want;

    function automatic t_out predict_drive(t_in smp);
        longint err, e1, third, delta, v, hi, lo, cap, kp, ki, kd;
        t_out   r;
        err   = longint'(smp.target) - longint'(smp.measured);
        e1    = longint'(err_prev);
        third = longint'(err_older_or_integral);
        kp    = longint'(gain_p);
        ki    = longint'(gain_i);
        kd    = longint'(gain_d);
        hi    = longint'(drive_max) * (longint'(1) << FRAC_W);
        lo    = longint'(drive_min) * (longint'(1) << FRAC_W);
        if (gain_mode == MODE_INC) begin
            delta = kp * (err - e1) + ki * err + kd * (err - 2 * e1 + third);
            err_older_or_integral = THIRD_W'(e1);
            v = longint'(drive_accum) + delta;
        end else begin
            cap   = longint'(integral_cap);
            third = third + err;
            if (third > cap)  third = cap;
            if (third < -cap) third = -cap;
            err_older_or_integral = THIRD_W'(third);
            v = kp * err + ki * third + kd * (err - e1);
        end
        err_prev = ERR_W'(err);
        // The upper clamp goes first, so crossed limits settle on the lower one.
        r.clamped = 1'b0;
        if (v > hi) begin
            v = hi;
            r.clamped = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            r.clamped = 1'b1;
        end
        if (gain_mode == MODE_INC) drive_accum = RUN_W'(v);
        // An arithmetic shift floors the fraction away.
        v = v >>> FRAC_W;
        r.drive = v[DATA_W-1:0];
        return r;
    endfunction

    // Input side: presents queued samples with a random gap after each transaction.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // Hold the sample until the block takes it.
            end else if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap--;
            end else if (samples_pending.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= samples_pending.pop_front();
                if ($urandom_range(0, 31) == 0) in_quiet = !in_quiet;
                in_gap = in_quiet ? 0 : $urandom_range(0, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: stalls for a random number of cycles after each transaction.
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (drive_expected.size() == 0) begin
                    $error("drive: result arrived with no sample outstanding");
                    failures++;
                end else begin
                    want = drive_expected.pop_front();
                    samples_owed--;
                    if (o_out_data.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d",
                               $signed(want.drive), $signed(o_out_data.drive));
                        failures++;
                    end
                    if (o_out_data.clamped !== want.clamped) begin
                        $error("clamped: expected %0b, actual %0b",
                               want.clamped, o_out_data.clamped);
                        failures++;
                    end
                end
                if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
                out_stall = out_quiet ? 0 : $urandom_range(0, 7);
            end
            if (i_in_valid && o_in_ready)
                drive_expected.push_back(predict_drive(i_in_data));
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    task automatic post_sample(int meas, int targ);
        t_in smp;
        smp.measured = meas[DATA_W-1:0];
        smp.target   = targ[DATA_W-1:0];
        samples_pending.push_back(smp);
        samples_owed++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_MODE:    gain_mode    = t_mode'(val[0]);
            CFG_KP:      gain_p       = val;
            CFG_KI:      gain_i       = val;
            CFG_KD:      gain_d       = val;
            CFG_OUT_MAX: drive_max    = val;
            CFG_OUT_MIN: drive_min    = val;
            CFG_ILIM:    integral_cap = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits for every outstanding result, then for the pipeline to drain.
    task automatic settle();
        while (samples_owed != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] draw_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom_range(0, 1023));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    initial begin
        int t;
        int m;
        int hi;
        int lo;

        gain_mode    = MODE_INC;
        gain_p       = KP_RST;
        gain_i       = KI_RST;
        gain_d       = KD_RST;
        drive_max    = OUT_MAX_RST;
        drive_min    = OUT_MIN_RST;
        integral_cap = ILIM_RST;
        err_prev              = '0;
        err_older_or_integral = '0;
        drive_accum           = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings, incremental form: zero error and both error extremes.
        post_sample(0, 0);
        post_sample(-32768, 32767);
        post_sample(32767, -32768);
        post_sample(0, 0);
        post_sample(100, 100);
        post_sample(-1, 0);
        post_sample(0, -1);
        post_sample(12, 345);
        settle();

        // Switch to positional form; the third state word carries over as the integral.
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_POS));
        end_writes();
        post_sample(0, 40);
        post_sample(0, 40);
        post_sample(0, -32768);
        post_sample(-32768, 32767);
        post_sample(5, 0);
        settle();

        // Crossed output limits: the lower limit wins and the flag is raised.
        write_reg(CFG_KD, 16'd256);
        write_reg(CFG_OUT_MAX, -16'sd10);
        write_reg(CFG_OUT_MIN, 16'sd10);
        end_writes();
        post_sample(0, 0);
        post_sample(0, 1000);
        post_sample(1000, 0);
        post_sample(0, 3);
        settle();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_INC));
        end_writes();
        post_sample(0, 0);
        post_sample(0, 2000);
        post_sample(2000, 0);
        settle();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_POS));
                write_reg(CFG_KP, '1);
                write_reg(CFG_KI, '1);
                write_reg(CFG_KD, '1);
                write_reg(CFG_OUT_MAX, 16'sd32767);
                write_reg(CFG_OUT_MIN, -16'sd32768);
                write_reg(CFG_ILIM, '1);
            end else if (ph == 1) begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_INC));
                write_reg(CFG_KP, '0);
                write_reg(CFG_KI, '0);
                write_reg(CFG_KD, '0);
                write_reg(CFG_OUT_MAX, 16'sd32767);
                write_reg(CFG_OUT_MIN, -16'sd32768);
                write_reg(CFG_ILIM, '0);
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        hi = 32767;
                        lo = -32768;
                    end
                    1: begin
                        hi = -$urandom_range(0, 1000);
                        lo = $urandom_range(1, 1000);
                    end
                    default: begin
                        hi = $urandom_range(0, 20000);
                        lo = -$urandom_range(0, 20000);
                    end
                endcase
                write_reg(CFG_MODE, CFG_DATA_W'(t_mode'($urandom_range(0, 1))));
                write_reg(CFG_KP, draw_gain());
                write_reg(CFG_KI, draw_gain());
                write_reg(CFG_KD, draw_gain());
                write_reg(CFG_OUT_MAX, hi[LIM_W-1:0]);
                write_reg(CFG_OUT_MIN, lo[LIM_W-1:0]);
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_ILIM, '0);
                    1:       write_reg(CFG_ILIM, '1);
                    default: write_reg(CFG_ILIM, LIM_W'($urandom_range(0, 2000)));
                endcase
            end
            end_writes();

            // Mostly samples close to the set point, so the loop is not always clamped.
            for (int n = 0; n < 50; n++) begin
                t = $urandom_range(0, 65535) - 32768;
                if ($urandom_range(0, 3) == 0) begin
                    m = $urandom_range(0, 65535) - 32768;
                end else begin
                    m = t + $urandom_range(0, 127) - 64;
                end
                post_sample(m, t);
            end
            settle();
        end

        repeat (8) @(negedge i_clk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
